/* rtl/core/tlb_fifo_lru_replacement_defines.svh */
// ----------------------------------------------------------------------------
// TLB assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TLB_FIFO_LRU_REPLACEMENT_DEFINES_SVH
`define TLB_FIFO_LRU_REPLACEMENT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TLBFL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TLBFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tlbfl_pkg.sv */
// ----------------------------------------------------------------------------
// tlbfl_pkg
// Operation codes, register indexes and controller states of the TLB.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbfl_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic {
    MODE_FIFO = 1'b0,
    MODE_LRU  = 1'b1
  } mode_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd1;

  localparam logic [CFG_DATA_W-1:0] ENTRIES_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIFO_READ,
    ST_WRITE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/tlbfl_entry_ram.sv */
// ----------------------------------------------------------------------------
// tlbfl_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbfl_entry_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 72
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/tlb_fifo_lru_replacement.sv */
// ----------------------------------------------------------------------------
// tlb_fifo_lru_replacement
// Fully associative TLB, page to frame, with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries op_i, page_i, frame_i.
//   Output channel (out_valid_o/out_ready_i) returns one transaction per
//   input: hit_o, frame_out_o, replaced_o, victim_page_o.
//   Config channel (cfg_valid_i/cfg_ready_o) writes replace_mode (index 0)
//   and entries_in_use (index 1); write only while the block is idle.
// A lookup scan reads up to the occupied entries that count (L), an LRU
//   eviction reads every entry of the effective size (S), one entry per
//   cycle from the entry memory with its registered read data; a FIFO
//   eviction reads only its victim; an insert with room, a clear or an unknown op reads none.
// One item is in flight at a time. The result sits in an output register,
//   so the next item is accepted while it waits; a finished item holds in
//   the done state only when the output register is still full.
// Reset clears occupancy, FIFO pointer and use counter and restores LRU mode
//   with 16 entries; the entry memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_fifo_lru_replacement #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_BITS   = 20,
  parameter int unsigned FRAME_BITS  = 20,
  parameter int unsigned STAMP_BITS  = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       op_i,
  input  wire logic [PAGE_BITS-1:0]             page_i,
  input  wire logic [FRAME_BITS-1:0]            frame_i,

  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  hit_o,
  output logic      [FRAME_BITS-1:0]            frame_out_o,
  output logic                                  replaced_o,
  output logic      [PAGE_BITS-1:0]             victim_page_o,

  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tlbfl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tlbfl_pkg::CFG_DATA_W-1:0] cfg_data_i
);

`include "tlb_fifo_lru_replacement_defines.svh"

  localparam int unsigned IDX_W  = $clog2(TLB_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(TLB_ENTRIES + 1);
  localparam int unsigned CMP_W  = (CNT_W > tlbfl_pkg::CFG_DATA_W) ? CNT_W
                                                                   : tlbfl_pkg::CFG_DATA_W;
  localparam int unsigned DATA_W = PAGE_BITS + FRAME_BITS + STAMP_BITS;

  // Control state
  tlbfl_pkg::state_e                 state_q, state_d;
  tlbfl_pkg::mode_e                  mode_q, mode_d;
  logic [tlbfl_pkg::CFG_DATA_W-1:0]  entries_q, entries_d;
  logic [CNT_W-1:0]                  occ_q, occ_d;
  logic [IDX_W-1:0]                  fifo_q, fifo_d;
  logic [STAMP_BITS-1:0]             use_q, use_d;
  logic                              pend_q, pend_d;
  logic                              out_valid_q, out_valid_d;

  // Item payload and scan bookkeeping
  logic [1:0]                        op_q, op_d;
  logic [PAGE_BITS-1:0]              page_q, page_d;
  logic [FRAME_BITS-1:0]             frame_q, frame_d;
  logic [CNT_W-1:0]                  issue_q, issue_d;
  logic [CNT_W-1:0]                  limit_q, limit_d;
  logic [IDX_W-1:0]                  pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0]                  waddr_q, waddr_d;
  logic [STAMP_BITS-1:0]             best_q, best_d;
  logic [PAGE_BITS-1:0]              victim_q, victim_d;
  logic                              res_hit_q, res_hit_d;
  logic                              res_repl_q, res_repl_d;

  // Output register
  logic                              hit_q, hit_d;
  logic [FRAME_BITS-1:0]             frame_out_q, frame_out_d;
  logic                              repl_q, repl_d;
  logic [PAGE_BITS-1:0]              vpage_q, vpage_d;

  // Memory port
  logic                              ram_we, ram_re;
  logic [IDX_W-1:0]                  ram_raddr;
  logic [DATA_W-1:0]                 ram_wdata, ram_rdata;
  logic [PAGE_BITS-1:0]              rd_page;
  logic [FRAME_BITS-1:0]             rd_frame;
  logic [STAMP_BITS-1:0]             rd_stamp;

  // Derived values
  logic [CMP_W-1:0]                  entries_ext;
  logic [CNT_W-1:0]                  size;
  logic [CNT_W-1:0]                  valid_cnt;
  logic [IDX_W-1:0]                  fifo_victim;
  logic [CNT_W-1:0]                  fifo_inc;
  logic [IDX_W-1:0]                  fifo_next;
  logic [STAMP_BITS-1:0]             use_next;

  tlbfl_entry_ram #(
    .DEPTH  (TLB_ENTRIES),
    .DATA_W (DATA_W)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_page   = ram_rdata[DATA_W-1 -: PAGE_BITS];
  assign rd_frame  = ram_rdata[STAMP_BITS +: FRAME_BITS];
  assign rd_stamp  = ram_rdata[STAMP_BITS-1:0];
  // A lookup hit writes back its own page and frame with a fresh stamp.
  assign ram_wdata = {page_q, frame_q, use_next};

  // Clamp the configured size into 1..TLB_ENTRIES.
  assign entries_ext = CMP_W'(entries_q);
  always_comb begin
    priority if (entries_ext == '0) begin
      size = CNT_W'(1);
    end else if (entries_ext > CMP_W'(TLB_ENTRIES)) begin
      size = CNT_W'(TLB_ENTRIES);
    end else begin
      size = entries_ext[CNT_W-1:0];
    end
  end

  // Entries past the current size do not count as occupied.
  assign valid_cnt = (occ_q < size) ? occ_q : size;

  // FIFO victim falls back to slot 0 when the pointer is outside the size.
  assign fifo_victim = (CNT_W'(fifo_q) < size) ? fifo_q : '0;
  assign fifo_inc    = CNT_W'(fifo_victim) + CNT_W'(1);
  assign fifo_next   = (fifo_inc < size) ? fifo_inc[IDX_W-1:0] : '0;

  // Saturating use counter.
  assign use_next = (use_q == {STAMP_BITS{1'b1}}) ? use_q : use_q + STAMP_BITS'(1);

  assign in_ready_o    = (state_q == tlbfl_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign frame_out_o   = frame_out_q;
  assign replaced_o    = repl_q;
  assign victim_page_o = vpage_q;

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    entries_d   = entries_q;
    occ_d       = occ_q;
    fifo_d      = fifo_q;
    use_d       = use_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    page_d      = page_q;
    frame_d     = frame_q;
    issue_d     = issue_q;
    limit_d     = limit_q;
    pend_idx_d  = pend_idx_q;
    waddr_d     = waddr_q;
    best_d      = best_q;
    victim_d    = victim_q;
    res_hit_d   = res_hit_q;
    res_repl_d  = res_repl_q;
    hit_d       = hit_q;
    frame_out_d = frame_out_q;
    repl_d      = repl_q;
    vpage_d     = vpage_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = issue_q[IDX_W-1:0];

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tlbfl_pkg::CFG_REPLACE_MODE:   mode_d = tlbfl_pkg::mode_e'(cfg_data_i[0]);
        tlbfl_pkg::CFG_ENTRIES_IN_USE: entries_d = cfg_data_i;
        default: ;
      endcase
    end

    // Drop the result once the receiver takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tlbfl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_i;
          page_d     = page_i;
          frame_d    = frame_i;
          res_hit_d  = 1'b0;
          res_repl_d = 1'b0;
          victim_d   = '0;
          issue_d    = '0;
          unique case (tlbfl_pkg::op_e'(op_i))
            tlbfl_pkg::OP_LOOKUP: begin
              limit_d = valid_cnt;
              state_d = tlbfl_pkg::ST_SCAN;
            end
            tlbfl_pkg::OP_INSERT: begin
              if (occ_q < size) begin
                waddr_d = occ_q[IDX_W-1:0];
                occ_d   = occ_q + CNT_W'(1);
                state_d = tlbfl_pkg::ST_WRITE;
              end else if (mode_q == tlbfl_pkg::MODE_FIFO) begin
                waddr_d    = fifo_victim;
                fifo_d     = fifo_next;
                ram_re     = 1'b1;
                ram_raddr  = fifo_victim;
                res_repl_d = 1'b1;
                state_d    = tlbfl_pkg::ST_FIFO_READ;
              end else begin
                limit_d    = size;
                res_repl_d = 1'b1;
                state_d    = tlbfl_pkg::ST_SCAN;
              end
            end
            tlbfl_pkg::OP_CLEAR: begin
              occ_d   = '0;
              state_d = tlbfl_pkg::ST_DONE;
            end
            default: begin
              state_d = tlbfl_pkg::ST_DONE;
            end
          endcase
        end
      end

      tlbfl_pkg::ST_SCAN: begin
        // Issue one read per cycle, compare the entry read the cycle before.
        if (issue_q < limit_q) begin
          ram_re     = 1'b1;
          issue_d    = issue_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = issue_q[IDX_W-1:0];
        end
        if (op_q == tlbfl_pkg::OP_LOOKUP) begin
          if (pend_q && (rd_page == page_q)) begin
            res_hit_d = 1'b1;
            frame_d   = rd_frame;
            waddr_d   = pend_idx_q;
            state_d   = tlbfl_pkg::ST_WRITE;
          end else if (!pend_q && (issue_q == limit_q)) begin
            state_d = tlbfl_pkg::ST_DONE;
          end
        end else begin
          // Strict compare keeps ties on the lowest index.
          if (pend_q && ((pend_idx_q == '0) || (rd_stamp < best_q))) begin
            best_d   = rd_stamp;
            waddr_d  = pend_idx_q;
            victim_d = rd_page;
          end
          if (!pend_q && (issue_q == limit_q)) begin
            state_d = tlbfl_pkg::ST_WRITE;
          end
        end
      end

      tlbfl_pkg::ST_FIFO_READ: begin
        victim_d = rd_page;
        state_d  = tlbfl_pkg::ST_WRITE;
      end

      tlbfl_pkg::ST_WRITE: begin
        ram_we  = 1'b1;
        use_d   = use_next;
        state_d = tlbfl_pkg::ST_DONE;
      end

      tlbfl_pkg::ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          hit_d       = res_hit_q;
          frame_out_d = res_hit_q ? frame_q : '0;
          repl_d      = res_repl_q;
          vpage_d     = res_repl_q ? victim_q : '0;
          state_d     = tlbfl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tlbfl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlbfl_pkg::ST_IDLE;
      mode_q      <= tlbfl_pkg::MODE_LRU;
      entries_q   <= tlbfl_pkg::ENTRIES_RESET;
      occ_q       <= '0;
      fifo_q      <= '0;
      use_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      entries_q   <= entries_d;
      occ_q       <= occ_d;
      fifo_q      <= fifo_d;
      use_q       <= use_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    page_q      <= page_d;
    frame_q     <= frame_d;
    issue_q     <= issue_d;
    limit_q     <= limit_d;
    pend_idx_q  <= pend_idx_d;
    waddr_q     <= waddr_d;
    best_q      <= best_d;
    victim_q    <= victim_d;
    res_hit_q   <= res_hit_d;
    res_repl_q  <= res_repl_d;
    hit_q       <= hit_d;
    frame_out_q <= frame_out_d;
    repl_q      <= repl_d;
    vpage_q     <= vpage_d;
  end

  // Assertions

  `TLBFL_ASSERT_SAME(a_occ_bound, 1'b1, occ_q <= CNT_W'(TLB_ENTRIES), "occupancy over capacity")

  `TLBFL_ASSERT_SAME(a_write_in_size, state_q == tlbfl_pkg::ST_WRITE, CNT_W'(waddr_q) < size, "write outside effective size")

  `TLBFL_ASSERT_NEXT(a_use_monotonic, 1'b1, use_q >= $past(use_q), "use counter went backward")

  `TLBFL_ASSERT_SAME(a_scan_limit, state_q == tlbfl_pkg::ST_SCAN, issue_q <= limit_q, "scan ran past its limit")

endmodule

`default_nettype wire
